FILE: src/lav_pkg.sv
package lav_pkg;

  localparam int unsigned DW   = 32;            // input / translation width
  localparam int unsigned AW   = 18;            // unit axis component width
  localparam int unsigned FRAC = 16;            // Q16.16 fraction bits
  localparam int unsigned PW   = AW + DW;       // axis x 32-bit product
  localparam int unsigned VW   = 51;            // signed width into a normaliser
  localparam int unsigned BLW  = $clog2(VW + 1);
  localparam int unsigned MW   = 30;            // scaled magnitude width
  localparam int unsigned SQW  = 64;            // sum of squares / root working width
  localparam int unsigned LW   = 31;            // root width
  localparam int unsigned QW   = FRAC + 1;      // quotient width
  localparam int unsigned NW   = MW + FRAC + 2; // dividend width
  localparam int unsigned IW   = 2;             // config index width

  localparam logic [IW-1:0] REG_UP_X = 2'd0;
  localparam logic [IW-1:0] REG_UP_Y = 2'd1;
  localparam logic [IW-1:0] REG_UP_Z = 2'd2;

  localparam logic [DW-1:0] UP_X_RST = 32'd0;
  localparam logic [DW-1:0] UP_Y_RST = 32'd65536;
  localparam logic [DW-1:0] UP_Z_RST = 32'd0;

  typedef logic [2:0][VW-1:0] vec_t;
  typedef logic [2:0][AW-1:0] axis_t;
  typedef logic [2:0][DW-1:0] word3_t;

  // values that ride alongside an item through the pipeline
  typedef struct packed {
    word3_t eye;
    axis_t  fwd;
    axis_t  rgt;
  } side_t;

endpackage

FILE: src/lav_ifs.sv
interface lav_in_if import lav_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] eye_x;
  logic [DW-1:0] eye_y;
  logic [DW-1:0] eye_z;
  logic [DW-1:0] target_x;
  logic [DW-1:0] target_y;
  logic [DW-1:0] target_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                output ready);
endinterface

interface lav_out_if import lav_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [AW-1:0] right_x;
  logic [AW-1:0] right_y;
  logic [AW-1:0] right_z;
  logic [AW-1:0] cam_up_x;
  logic [AW-1:0] cam_up_y;
  logic [AW-1:0] cam_up_z;
  logic [AW-1:0] back_x;
  logic [AW-1:0] back_y;
  logic [AW-1:0] back_z;
  logic [DW-1:0] shift_right;
  logic [DW-1:0] shift_up;
  logic [DW-1:0] shift_forward;

  modport source (output valid, right_x, right_y, right_z, cam_up_x, cam_up_y, cam_up_z,
                  back_x, back_y, back_z, shift_right, shift_up, shift_forward,
                  input ready);
  modport sink (input valid, right_x, right_y, right_z, cam_up_x, cam_up_y, cam_up_z,
                back_x, back_y, back_z, shift_right, shift_up, shift_forward,
                output ready);
endinterface

interface lav_cfg_if import lav_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/lav_unit.sv
module lav_unit import lav_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  vec_t  v_i,
  input  side_t side_i,
  output logic  valid_o,
  output axis_t axis_o,
  output side_t side_o
);

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
    side_t              side;
  } carry_t;

  // stage 1: magnitudes and their OR
  logic               s1_valid_q;
  logic [2:0][VW-1:0] s1_mag_q, mag_d;
  logic [2:0]         s1_neg_q;
  logic [VW-1:0]      s1_or_q;
  side_t              s1_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = v_i[i][VW-1] ? ({VW{1'b0}} - v_i[i]) : v_i[i];
    end
  end

  // stage 2: bit length of the largest magnitude
  logic               s2_valid_q;
  logic [2:0][VW-1:0] s2_mag_q;
  logic [2:0]         s2_neg_q;
  logic [BLW-1:0]     s2_blen_q, blen_d;
  side_t              s2_side_q;

  always_comb begin
    blen_d = '0;
    for (int b = 0; b < VW; b++) begin
      if (s1_or_q[b]) blen_d = BLW'(b + 1);
    end
  end

  // stage 3: scale so the largest lies in [2^29, 2^30)
  logic   s3_valid_q;
  carry_t s3_q, s3_d;

  always_comb begin
    logic [VW-1:0] sh;
    s3_d.neg  = s2_neg_q;
    s3_d.zero = (s2_blen_q == '0);
    s3_d.side = s2_side_q;
    for (int i = 0; i < 3; i++) begin
      if (s2_blen_q > BLW'(MW)) begin
        sh = s2_mag_q[i] >> (s2_blen_q - BLW'(MW));
      end else begin
        sh = s2_mag_q[i] << (BLW'(MW) - s2_blen_q);
      end
      s3_d.m[i] = sh[MW-1:0];
    end
  end

  // stage 4: squares, stage 5: sum
  logic                 s4_valid_q;
  carry_t               s4_q;
  logic [2:0][2*MW-1:0] s4_sq_q;

  logic               sq_v_q [LW+1];
  carry_t             sq_c_q [LW+1];
  logic [SQW-1:0]     sq_n_q [LW+1];
  logic [SQW-1:0]     sq_r_q [LW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      sq_v_q[0]  <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      sq_v_q[0]  <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q  <= mag_d;
      for (int i = 0; i < 3; i++) s1_neg_q[i] <= v_i[i][VW-1];
      s1_or_q   <= mag_d[0] | mag_d[1] | mag_d[2];
      s1_side_q <= side_i;
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_blen_q <= blen_d;
      s2_side_q <= s1_side_q;
      s3_q      <= s3_d;
      s4_q      <= s3_q;
      for (int i = 0; i < 3; i++) s4_sq_q[i] <= s3_q.m[i] * s3_q.m[i];
      sq_c_q[0] <= s4_q;
      sq_n_q[0] <= SQW'(s4_sq_q[0]) + SQW'(s4_sq_q[1]) + SQW'(s4_sq_q[2]);
      sq_r_q[0] <= '0;
    end
  end

  // integer square root, one result bit a stage
  for (genvar g = 0; g < LW; g++) begin : g_sqrt
    localparam logic [SQW-1:0] Bit = SQW'(1) << (2 * (LW - 1 - g));
    logic [SQW-1:0] t, n_d, r_d;

    always_comb begin
      t = sq_r_q[g] + Bit;
      if (sq_n_q[g] >= t) begin
        n_d = sq_n_q[g] - t;
        r_d = (sq_r_q[g] >> 1) + Bit;
      end else begin
        n_d = sq_n_q[g];
        r_d = sq_r_q[g] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[g+1] <= sq_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_n_q[g+1] <= n_d;
        sq_r_q[g+1] <= r_d;
        sq_c_q[g+1] <= sq_c_q[g];
      end
    end
  end

  // rounded division by the length, one quotient bit a stage
  logic               dv_v_q [QW+1];
  carry_t             dv_c_q [QW+1];
  logic [LW-1:0]      dv_l_q [QW+1];
  logic [2:0][NW-1:0] dv_r_q [QW+1];
  logic [2:0][QW-1:0] dv_q_q [QW+1];
  logic [LW-1:0]      len;

  assign len = sq_r_q[LW][LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= sq_v_q[LW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_c_q[0] <= sq_c_q[LW];
      dv_l_q[0] <= len;
      dv_q_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_r_q[0][i] <= NW'({sq_c_q[LW].m[i], {FRAC{1'b0}}}) + NW'(len >> 1);
      end
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int unsigned J = QW - 1 - g;
    logic [NW-1:0]      dsr;
    logic [2:0][NW-1:0] r_d;
    logic [2:0][QW-1:0] q_d;

    always_comb begin
      dsr = NW'(dv_l_q[g]) << J;
      for (int i = 0; i < 3; i++) begin
        q_d[i] = dv_q_q[g][i];
        if (dv_r_q[g][i] >= dsr) begin
          r_d[i]    = dv_r_q[g][i] - dsr;
          q_d[i][J] = 1'b1;
        end else begin
          r_d[i] = dv_r_q[g][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[g+1] <= dv_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_c_q[g+1] <= dv_c_q[g];
        dv_l_q[g+1] <= dv_l_q[g];
        dv_r_q[g+1] <= r_d;
        dv_q_q[g+1] <= q_d;
      end
    end
  end

  // final: sign back on, zero vector gives zero axis
  logic  f_valid_q;
  axis_t f_axis_q, axis_d;
  side_t f_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_c_q[QW].zero) begin
        axis_d[i] = '0;
      end else if (dv_c_q[QW].neg[i]) begin
        axis_d[i] = AW'(0) - AW'(dv_q_q[QW][i]);
      end else begin
        axis_d[i] = AW'(dv_q_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_axis_q <= axis_d;
      f_side_q <= dv_c_q[QW].side;
    end
  end

  assign valid_o = f_valid_q;
  assign axis_o  = f_axis_q;
  assign side_o  = f_side_q;

endmodule

FILE: src/lav_cross.sv
module lav_cross import lav_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  axis_t  a_i,
  input  word3_t b_i,
  input  side_t  side_i,
  output logic   valid_o,
  output vec_t   v_o,
  output side_t  side_o
);

  logic               p_valid_q, v_valid_q;
  logic [5:0][PW-1:0] p_q, p_d;
  side_t              p_side_q, v_side_q;
  vec_t               v_q;

  always_comb begin
    p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      v_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
      v_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q      <= p_d;
      p_side_q <= side_i;
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= VW'($signed(p_q[2*i])) - VW'($signed(p_q[2*i+1]));
      end
      v_side_q <= p_side_q;
    end
  end

  assign valid_o = v_valid_q;
  assign v_o     = v_q;
  assign side_o  = v_side_q;

endmodule

FILE: src/look_at_view_matrix_top.sv
// Look-at view matrix, signed Q16.16.
// in_i carries an eye position and a target point; out_o carries one item
// per input item: the right, camera up and back (negated forward) unit axes
// as 18-bit signed Q2.16, and the three saturated 32-bit translations.
// cfg_i writes the world up vector: index 0..2 = up x, y, z; index 3 is
// ignored. cfg_i is always ready; write it only while no item is in flight.
// From accept to out_o.valid the pipeline holds three normalisers of 55
// stages each (31-stage square root, 17-stage divider), two 2-stage cross
// products, a 2-stage dot product, input and output registers.
// Throughput is one item per cycle while out_o is taken.
// The whole pipeline advances together; while out_o holds an item that is
// not taken, in_i.ready is low and every stage holds, so nothing is lost.
// Reset clears every valid bit and sets up to (0, 1.0, 0).
module look_at_view_matrix_top import lav_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lav_in_if.sink     in_i,
  lav_out_if.source  out_o,
  lav_cfg_if.sink    cfg_i
);

  logic   adv;
  word3_t up_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= UP_X_RST;
      up_q[1] <= UP_Y_RST;
      up_q[2] <= UP_Z_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_UP_X: up_q[0] <= cfg_i.data;
        REG_UP_Y: up_q[1] <= cfg_i.data;
        REG_UP_Z: up_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // input stage: forward = target - eye
  logic  t0_valid_q;
  vec_t  t0_d_q;
  side_t t0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_valid_q <= 1'b0;
    end else if (adv) begin
      t0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_d_q[0] <= VW'($signed(in_i.target_x)) - VW'($signed(in_i.eye_x));
      t0_d_q[1] <= VW'($signed(in_i.target_y)) - VW'($signed(in_i.eye_y));
      t0_d_q[2] <= VW'($signed(in_i.target_z)) - VW'($signed(in_i.eye_z));
      t0_side_q.eye[0] <= in_i.eye_x;
      t0_side_q.eye[1] <= in_i.eye_y;
      t0_side_q.eye[2] <= in_i.eye_z;
      t0_side_q.fwd    <= '0;
      t0_side_q.rgt    <= '0;
    end
  end

  logic   a_valid, x1_valid, b_valid, x2_valid, c_valid;
  axis_t  fwd, rgt, cup;
  side_t  a_side, a_side_f, x1_side, b_side, b_side_r, x2_side, c_side;
  vec_t   x1_v, x2_v;
  word3_t fwd_w;

  lav_unit u_fwd (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(t0_valid_q), .v_i(t0_d_q), .side_i(t0_side_q),
    .valid_o(a_valid), .axis_o(fwd), .side_o(a_side)
  );

  always_comb begin
    a_side_f     = a_side;
    a_side_f.fwd = fwd;
  end

  lav_cross u_cross_r (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(a_valid), .a_i(fwd), .b_i(up_q), .side_i(a_side_f),
    .valid_o(x1_valid), .v_o(x1_v), .side_o(x1_side)
  );

  lav_unit u_rgt (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(x1_valid), .v_i(x1_v), .side_i(x1_side),
    .valid_o(b_valid), .axis_o(rgt), .side_o(b_side)
  );

  always_comb begin
    b_side_r     = b_side;
    b_side_r.rgt = rgt;
    for (int i = 0; i < 3; i++) fwd_w[i] = DW'($signed(b_side.fwd[i]));
  end

  lav_cross u_cross_u (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(b_valid), .a_i(rgt), .b_i(fwd_w), .side_i(b_side_r),
    .valid_o(x2_valid), .v_o(x2_v), .side_o(x2_side)
  );

  lav_unit u_cup (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(x2_valid), .v_i(x2_v), .side_i(x2_side),
    .valid_o(c_valid), .axis_o(cup), .side_o(c_side)
  );

  // translations: products, then sums
  localparam int unsigned SW = PW + 2;
  localparam int unsigned TW = SW - FRAC;

  logic                  d1_valid_q, d2_valid_q;
  logic [2:0][2:0][PW-1:0] d1_p_q;
  axis_t                 d1_rgt_q, d1_cup_q, d1_fwd_q, d2_rgt_q, d2_cup_q, d2_fwd_q;
  logic [2:0][SW-1:0]    d2_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q <= 1'b0;
      d2_valid_q <= 1'b0;
    end else if (adv) begin
      d1_valid_q <= c_valid;
      d2_valid_q <= d1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_p_q[0][i] <= $signed(c_side.rgt[i]) * $signed(c_side.eye[i]);
        d1_p_q[1][i] <= $signed(cup[i]) * $signed(c_side.eye[i]);
        d1_p_q[2][i] <= $signed(c_side.fwd[i]) * $signed(c_side.eye[i]);
      end
      d1_rgt_q <= c_side.rgt;
      d1_cup_q <= cup;
      d1_fwd_q <= c_side.fwd;
      for (int k = 0; k < 3; k++) begin
        d2_s_q[k] <= SW'($signed(d1_p_q[k][0])) + SW'($signed(d1_p_q[k][1]))
                   + SW'($signed(d1_p_q[k][2])) + SW'(32768);
      end
      d2_rgt_q <= d1_rgt_q;
      d2_cup_q <= d1_cup_q;
      d2_fwd_q <= d1_fwd_q;
    end
  end

  function automatic logic [DW-1:0] sat_w(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] hi, lo;
    hi = TW'(2147483647);
    lo = -hi - TW'(1);
    if (v > hi) return DW'(hi);
    if (v < lo) return DW'(lo);
    return v[DW-1:0];
  endfunction

  logic signed [2:0][TW-1:0] tr;
  always_comb begin
    for (int k = 0; k < 3; k++) tr[k] = TW'($signed(d2_s_q[k]) >>> FRAC);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.right_x       <= d2_rgt_q[0];
      out_o.right_y       <= d2_rgt_q[1];
      out_o.right_z       <= d2_rgt_q[2];
      out_o.cam_up_x      <= d2_cup_q[0];
      out_o.cam_up_y      <= d2_cup_q[1];
      out_o.cam_up_z      <= d2_cup_q[2];
      out_o.back_x        <= AW'(0) - d2_fwd_q[0];
      out_o.back_y        <= AW'(0) - d2_fwd_q[1];
      out_o.back_z        <= AW'(0) - d2_fwd_q[2];
      out_o.shift_right   <= sat_w(TW'(0) - tr[0]);
      out_o.shift_up      <= sat_w(TW'(0) - tr[1]);
      out_o.shift_forward <= sat_w(tr[2]);
    end
  end

  assign out_o.valid = out_valid_q;

  // a stalled result freezes the pipeline entrance
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while result stalled");

  // normalised axis components right x, camera up y and back z never exceed unit length
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.right_x) <= 65536 && $signed(out_o.right_x) >= -65536
                  && $signed(out_o.cam_up_y) <= 65536 && $signed(out_o.cam_up_y) >= -65536
                  && $signed(out_o.back_z) <= 65536 && $signed(out_o.back_z) >= -65536))
    else $error("axis component out of range");

  // a held result stays valid and its forward shift does not change under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.shift_forward)))
    else $error("stalled result changed");

endmodule
